/* hw/rtl/udiv_pkg.sv */
// Shared types and constants for the 128-bit unsigned divider.
// Holds the controller/datapath command and status structs; no dependencies.
`timescale 1ns / 1ps

package udiv_pkg;

  localparam int HALF_W = 64;
  localparam int FULL_W = 2 * HALF_W;

  typedef struct packed {
    logic load;     // latch operands, clear partial remainder
    logic step;     // retire one quotient bit
    logic capture;  // copy results into the output registers
  } udiv_cmd_t;

  typedef struct packed {
    logic den_zero; // latched divisor was zero
  } udiv_status_t;

endpackage

/* hw/rtl/udiv_datapath.sv */
// Datapath of the divider: operand, partial remainder and result registers.
// Restoring shift-subtract step, one quotient bit per step. Uses udiv_pkg.
`timescale 1ns / 1ps

module udiv_datapath #(
  parameter int OPERAND_WIDTH = 128
) (
  input  logic                     clk,
  input  logic [63:0]              dividend_hi,
  input  logic [63:0]              dividend_lo,
  input  logic [63:0]              divisor_hi,
  input  logic [63:0]              divisor_lo,
  input  udiv_pkg::udiv_cmd_t      cmd,
  output udiv_pkg::udiv_status_t   status,
  output logic [63:0]              quotient_hi,
  output logic [63:0]              quotient_lo,
  output logic [63:0]              remainder_hi,
  output logic [63:0]              remainder_lo,
  output logic                     zero_divisor
);
  import udiv_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [FULL_W-1:0] dividend_full;
  logic [FULL_W-1:0] divisor_full;
  logic [W-1:0]      num_in;
  logic [W-1:0]      den_in;

  // nq shifts dividend bits out the top and quotient bits in at the bottom
  logic [W-1:0]      nq;
  logic [W-1:0]      rem;
  logic [W-1:0]      den;
  logic              zflag;

  logic [W:0]        shifted;
  logic [W+1:0]      trial;
  logic              ge;
  logic [W-1:0]      rem_next;
  logic [W-1:0]      nq_next;

  logic [FULL_W-1:0] quo_out;
  logic [FULL_W-1:0] rem_out;
  logic              zero_out;

  assign dividend_full = {dividend_hi, dividend_lo};
  assign divisor_full  = {divisor_hi, divisor_lo};
  assign num_in        = dividend_full[W-1:0];
  assign den_in        = divisor_full[W-1:0];

  always_comb begin
    shifted  = {rem, nq[W-1]};
    trial    = {1'b0, shifted} - {2'b00, den};
    ge       = ~trial[W+1];
    rem_next = ge ? trial[W-1:0] : shifted[W-1:0];
    nq_next  = {nq[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nq    <= num_in;
      den   <= den_in;
      rem   <= '0;
      zflag <= (den_in == '0);
    end else if (cmd.step) begin
      nq  <= nq_next;
      rem <= rem_next;
    end
    if (cmd.capture) begin
      // zero divisor: all-ones quotient, dividend (never stepped) as remainder
      quo_out  <= zflag ? FULL_W'({W{1'b1}}) : FULL_W'(nq);
      rem_out  <= zflag ? FULL_W'(nq) : FULL_W'(rem);
      zero_out <= zflag;
    end
  end

  assign status.den_zero = zflag;

  assign quotient_hi  = quo_out[FULL_W-1:HALF_W];
  assign quotient_lo  = quo_out[HALF_W-1:0];
  assign remainder_hi = rem_out[FULL_W-1:HALF_W];
  assign remainder_lo = rem_out[HALF_W-1:0];
  assign zero_divisor = zero_out;

endmodule

/* hw/rtl/udiv_ctrl.sv */
// Controller of the divider: sequences load, the division steps and capture.
// Drives the datapath through udiv_pkg command/status structs.
`timescale 1ns / 1ps

module udiv_ctrl #(
  parameter int OPERAND_WIDTH = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  udiv_pkg::udiv_status_t  status,
  output udiv_pkg::udiv_cmd_t     cmd,
  output logic                    busy,
  output logic                    done
);
  import udiv_pkg::*;

  localparam int CNT_W = $clog2(OPERAND_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OPERAND_WIDTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cmd.load    = start && (state == S_IDLE);
    cmd.step    = (state == S_RUN) && !status.den_zero;
    cmd.capture = (state == S_FIN);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (status.den_zero || cnt == LAST_STEP) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> done)
    else $error("capture not followed by done strobe");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("done strobe without capture");

  a_no_step_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.den_zero && !cmd.load && !cmd.capture)
    else $error("step issued on zero divisor or with another command");

endmodule

/* hw/rtl/u128_unsigned_divider.sv */
// Top level of the 128-bit unsigned divider.
// Instantiates udiv_ctrl and udiv_datapath; uses udiv_pkg.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive the four operand halves and raise start while busy
//   is low; the transaction is taken at that clock edge. Operand bits at and
//   above OPERAND_WIDTH are ignored.
//   Result channel: done is high for exactly one cycle, with quotient,
//   remainder and zero_divisor valid in that cycle. The receiver cannot stall;
//   sample the results while done is high (they also hold until the next
//   transaction finishes).
//   The operands are loaded at the accepting edge, then the shift-subtract
//   loop retires one quotient bit per cycle, and the results are captured as
//   done is raised. A zero divisor skips the loop.
//   Busy stays high through the loop and the capture, so a new transaction
//   can be taken in the done cycle.
//   Zero divisor: zero_divisor is set, the quotient is all ones within
//   OPERAND_WIDTH bits and the remainder is the dividend.
//   Reset (rst, synchronous): return to idle and drop any transaction in
//   flight; no done strobe follows for it.
module u128_unsigned_divider #(
  parameter int OPERAND_WIDTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] dividend_hi,
  input  logic [63:0] dividend_lo,
  input  logic [63:0] divisor_hi,
  input  logic [63:0] divisor_lo,
  output logic        done,
  output logic [63:0] quotient_hi,
  output logic [63:0] quotient_lo,
  output logic [63:0] remainder_hi,
  output logic [63:0] remainder_lo,
  output logic        zero_divisor
);
  import udiv_pkg::*;

  udiv_cmd_t    cmd;
  udiv_status_t status;

  // Sequence load, one step per quotient bit, then capture and strobe.
  udiv_ctrl #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Hold operands, partial remainder and the output registers.
  udiv_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .dividend_hi  (dividend_hi),
    .dividend_lo  (dividend_lo),
    .divisor_hi   (divisor_hi),
    .divisor_lo   (divisor_lo),
    .cmd          (cmd),
    .status       (status),
    .quotient_hi  (quotient_hi),
    .quotient_lo  (quotient_lo),
    .remainder_hi (remainder_hi),
    .remainder_lo (remainder_lo),
    .zero_divisor (zero_divisor)
  );

endmodule
